[src/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define RGBC_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rgbc assertion failed");

// Implication after a fixed number of cycles.
`define RGBC_ASSERT_DLY(label, clk_s, rst_s, ante, n, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> ##n (cons)) \
    else $error("rgbc assertion failed");

`endif

[src/rgbc_pkg.sv]
// Types and constants for the RGBC to HSL converter.
// No dependencies.
`timescale 1ns / 1ps

package rgbc_pkg;

  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [6:0] LIGHT_MID = 7'd50;
  localparam logic [7:0] SUM_FULL  = 8'd200;
  localparam logic [5:0] HUE_STEP  = 6'd60;
  localparam logic [8:0] HUE_RED   = 9'd0;
  localparam logic [8:0] HUE_GREEN = 9'd120;
  localparam logic [8:0] HUE_BLUE  = 9'd240;
  localparam logic [8:0] HUE_WRAP  = 9'd360;
  localparam int unsigned Q_BITS   = 7;

  // Sideband carried through the hue divider.
  typedef struct packed {
    logic       fault;
    logic       grey;
    logic       neg;
    logic [8:0] offset;
    logic [6:0] light;
  } hsl_side_t;

endpackage

[src/rgbc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, shared denominator.
// Depends on nothing; used by rgbc_to_hsl_converter_core.
`timescale 1ns / 1ps

module rgbc_div #(
  parameter int N_W    = 23,
  parameter int D_W    = 16,
  parameter int Q_BITS = 7,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  logic [LANES-1:0][N_W-1:0]     num,
  input  logic [D_W-1:0]                den,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          valid_out,
  output logic [LANES-1:0][Q_BITS-1:0]  quo,
  output logic [LANES-1:0]              ovf,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int CW = (N_W > D_W + Q_BITS) ? N_W : D_W + Q_BITS;

  logic [Q_BITS:0]       v;
  logic [CW-1:0]         rem    [0:Q_BITS][0:LANES-1];
  logic [Q_BITS-1:0]     q      [0:Q_BITS][0:LANES-1];
  logic                  ov     [0:Q_BITS][0:LANES-1];
  logic [D_W-1:0]        den_r  [0:Q_BITS];
  logic [SIDE_W-1:0]     side_r [0:Q_BITS];

  // Entry stage: latch operands, flag quotients that do not fit.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= valid_in;
    end
    den_r[0]  <= den;
    side_r[0] <= side_in;
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] <= CW'(num[l]);
      q[0][l]   <= '0;
      ov[0][l]  <= CW'(num[l]) >= (CW'(den) << Q_BITS);
    end
  end

  for (genvar s = 0; s < Q_BITS; s++) begin : g_step
    localparam int SH = Q_BITS - 1 - s;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      den_r[s+1]  <= den_r[s];
      side_r[s+1] <= side_r[s];
      for (int l = 0; l < LANES; l++) begin
        ov[s+1][l] <= ov[s][l];
        if (rem[s][l] >= (CW'(den_r[s]) << SH)) begin
          rem[s+1][l] <= rem[s][l] - (CW'(den_r[s]) << SH);
          q[s+1][l]   <= q[s][l] | (Q_BITS'(1) << SH);
        end else begin
          rem[s+1][l] <= rem[s][l];
          q[s+1][l]   <= q[s][l];
        end
      end
    end
  end

  assign valid_out = v[Q_BITS];
  assign side_out  = side_r[Q_BITS];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = q[Q_BITS][l];
      ovf[l] = ov[Q_BITS][l];
    end
  end

endmodule

[src/rgbc_to_hsl_converter_core.sv]
// Top level of the RGBC to HSL converter.
// Depends on rgbc_pkg, rgbc_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts one color-sensor word (red, green, blue, clear counts) into hue in
// degrees, saturation and lightness in percent. A word is taken on every
// clock edge where start is high; busy is always low, so a new word may enter
// every cycle. Each result is held for one cycle with done high; the receiver
// cannot stall, so it must sample on done. The path runs through two levels
// of 8-stage pipelined dividers (color over clear, then the hue and
// saturation quotients side by side) plus three register stages between and
// after them. A clear count of zero returns zeros with zero_clear_fault
// set. Percentages above 100 clamp to 100.
module rgbc_to_hsl_converter_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_count,
  input  logic [15:0] green_count,
  input  logic [15:0] blue_count,
  input  logic [15:0] clear_count,
  output logic        done,
  output logic [8:0]  hue_degrees,
  output logic [6:0]  saturation_pct,
  output logic [6:0]  lightness_pct,
  output logic        zero_clear_fault
);

  localparam int PW      = COUNT_BITS + 7;          // count * 100
  localparam int QB      = rgbc_pkg::Q_BITS;
  localparam int LATENCY = 2 * (QB + 1) + 3;
  localparam int SIDE_W  = $bits(rgbc_pkg::hsl_side_t);

  // Fully pipelined: never busy.
  assign busy = 1'b0;

  // ---- Color percentages: count * 100 / clear ----
  logic [2:0][PW-1:0]  c_num;
  logic [2:0][QB-1:0]  c_quo;
  logic [2:0]          c_ovf;
  logic                c_valid, c_fault;

  assign c_num[0] = PW'(red_count[COUNT_BITS-1:0])   * PW'(rgbc_pkg::PCT_FULL);
  assign c_num[1] = PW'(green_count[COUNT_BITS-1:0]) * PW'(rgbc_pkg::PCT_FULL);
  assign c_num[2] = PW'(blue_count[COUNT_BITS-1:0])  * PW'(rgbc_pkg::PCT_FULL);

  rgbc_div #(
    .N_W(PW), .D_W(COUNT_BITS), .Q_BITS(QB), .LANES(3), .SIDE_W(1)
  ) u_color_div (
    .clk(clk), .rst(rst),
    .valid_in(start & ~busy),
    .num(c_num),
    .den(clear_count[COUNT_BITS-1:0]),
    .side_in(clear_count[COUNT_BITS-1:0] == '0),
    .valid_out(c_valid),
    .quo(c_quo),
    .ovf(c_ovf),
    .side_out(c_fault)
  );

  // ---- Stage B: clamp to 100 ----
  logic       b_valid, b_fault;
  logic [6:0] b_pct [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= c_valid;
    end
    b_fault <= c_fault;
    for (int l = 0; l < 3; l++) begin
      b_pct[l] <= (c_ovf[l] || c_quo[l] > rgbc_pkg::PCT_FULL) ? rgbc_pkg::PCT_FULL : c_quo[l];
    end
  end

  // ---- Stage C: max/min, sector pick, divider operands ----
  logic [6:0] r, g, b, mx, mn, dif, sa, sb, sdiff;
  logic [7:0] sum, den_s_next;
  logic [8:0] off;
  rgbc_pkg::hsl_side_t side_next;

  always_comb begin
    r = b_pct[0];
    g = b_pct[1];
    b = b_pct[2];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dif = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    // red wins ties over green, green over blue
    if (r >= g && r >= b) begin
      sa  = g;
      sb  = b;
      off = (g >= b) ? rgbc_pkg::HUE_RED : rgbc_pkg::HUE_WRAP;
    end else if (g >= b) begin
      sa  = b;
      sb  = r;
      off = rgbc_pkg::HUE_GREEN;
    end else begin
      sa  = r;
      sb  = g;
      off = rgbc_pkg::HUE_BLUE;
    end
    sdiff = (sa >= sb) ? sa - sb : sb - sa;
    side_next.fault  = b_fault;
    side_next.grey   = (dif == '0);
    side_next.neg    = (sa < sb);
    side_next.offset = off;
    side_next.light  = sum[7:1];
    den_s_next = (sum[7:1] <= rgbc_pkg::LIGHT_MID) ? sum : rgbc_pkg::SUM_FULL - sum;
  end

  logic                c_valid2;
  logic [0:0][12:0]    h_num;
  logic [0:0][13:0]    s_num;
  logic [6:0]          h_den;
  logic [7:0]          s_den;
  rgbc_pkg::hsl_side_t h_side;
  logic                s_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid2 <= 1'b0;
    end else begin
      c_valid2 <= b_valid;
    end
    h_num[0] <= 13'(sdiff) * 13'(rgbc_pkg::HUE_STEP);
    s_num[0] <= 14'(dif) * 14'(rgbc_pkg::PCT_FULL);
    h_den    <= dif;
    s_den    <= den_s_next;
    h_side   <= side_next;
    s_zero   <= side_next.grey | b_fault;
  end

  // ---- Hue and saturation quotients ----
  logic [0:0][QB-1:0] h_quo, s_quo;
  logic [0:0]         h_ovf, s_ovf;
  logic               h_valid, s_valid, o_zero;
  logic [SIDE_W-1:0]  o_side_bits;
  rgbc_pkg::hsl_side_t o_side;

  rgbc_div #(
    .N_W(13), .D_W(7), .Q_BITS(QB), .LANES(1), .SIDE_W(SIDE_W)
  ) u_hue_div (
    .clk(clk), .rst(rst),
    .valid_in(c_valid2),
    .num(h_num),
    .den(h_den),
    .side_in(h_side),
    .valid_out(h_valid),
    .quo(h_quo),
    .ovf(h_ovf),
    .side_out(o_side_bits)
  );

  rgbc_div #(
    .N_W(14), .D_W(8), .Q_BITS(QB), .LANES(1), .SIDE_W(1)
  ) u_sat_div (
    .clk(clk), .rst(rst),
    .valid_in(c_valid2),
    .num(s_num),
    .den(s_den),
    .side_in(s_zero),
    .valid_out(s_valid),
    .quo(s_quo),
    .ovf(s_ovf),
    .side_out(o_zero)
  );

  assign o_side = rgbc_pkg::hsl_side_t'(o_side_bits);

  // ---- Output stage ----
  logic [8:0] hq;
  logic [6:0] sq;

  always_comb begin
    hq = h_ovf[0] ? 9'(rgbc_pkg::HUE_STEP) : 9'(h_quo[0]);
    sq = (s_ovf[0] || s_quo[0] > rgbc_pkg::PCT_FULL) ? rgbc_pkg::PCT_FULL : s_quo[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_valid & s_valid;
    end
    zero_clear_fault <= o_side.fault;
    lightness_pct    <= o_side.fault ? '0 : o_side.light;
    saturation_pct   <= o_zero ? '0 : sq;
    if (o_side.fault || o_side.grey) begin
      hue_degrees <= '0;
    end else if (o_side.neg) begin
      hue_degrees <= o_side.offset - hq;
    end else begin
      hue_degrees <= o_side.offset + hq;
    end
  end

  // ---- Assertions ----
  `RGBC_ASSERT_DLY(a_latency, clk, rst, start, LATENCY, done)
  `RGBC_ASSERT_IMP(a_fault_zero, clk, rst, done && zero_clear_fault,
    hue_degrees == '0 && saturation_pct == '0 && lightness_pct == '0)
  `RGBC_ASSERT_IMP(a_range, clk, rst, done,
    hue_degrees <= rgbc_pkg::HUE_WRAP && saturation_pct <= rgbc_pkg::PCT_FULL &&
    lightness_pct <= rgbc_pkg::PCT_FULL)

endmodule
